/* hw/rtl/tssd_pkg.sv */
package tssd_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_SCAN    = 2'd1,
    CMD_REFRESH = 2'd2
  } cmd_t;

  localparam logic REG_DWELL   = 1'b0;
  localparam logic REG_REFRESH = 1'b1;

  localparam logic [15:0] DWELL_RESET   = 16'd5000;
  localparam logic [15:0] REFRESH_RESET = 16'd500;

  // hundredths = code * 3125 / 64
  localparam logic [21:0] SCALE_MUL   = 22'd3125;
  // floor(h / 1000) = (h * 67109) >> 26, exact for h < 2^16
  localparam logic [32:0] DIV1000_MUL = 33'd67109;
  // floor(r / 100) = (r * 41) >> 12, exact for r < 1000
  localparam logic [15:0] DIV100_MUL  = 16'd41;
  // floor(r / 10) = (r * 205) >> 11, exact for r < 100
  localparam logic [14:0] DIV10_MUL   = 15'd205;

  localparam logic [7:0] SEG_DP = 8'h01;

  typedef struct packed {
    logic [5:0] th;
    logic [3:0] hd;
    logic [3:0] td;
    logic [3:0] ud;
  } digits_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  sample;
    logic [15:0] hund;
    logic [5:0]  th;
    logic [9:0]  r1;
    logic [3:0]  hd;
    logic [6:0]  r2;
    logic [3:0]  td;
  } pipe_t;

  function automatic logic [7:0] glyph(input logic [5:0] d);
    logic [7:0] g;
    case (d)
      6'd0: g = 8'h7E;
      6'd1: g = 8'h12;
      6'd2: g = 8'hBC;
      6'd3: g = 8'hB6;
      6'd4: g = 8'hD2;
      6'd5: g = 8'hE6;
      6'd6: g = 8'hCE;
      6'd7: g = 8'h32;
      6'd8: g = 8'hFE;
      6'd9: g = 8'hF2;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/temperature_seven_segment_display_top.sv */
// Temperature display driver for a four-digit multiplexed seven-segment panel.
// Input channel (item_valid/item_stall) carries one beat per event: cmd selects
// an ADC sample (sample field), a scan tick or a refresh tick. Every input beat
// produces exactly one output beat (result_valid/result_stall) holding the
// segment pattern and one-hot digit enable of the digit lit after that event,
// plus the latest converted temperature in hundredths of a degree.
// Throughput: one beat per cycle while result_stall is low. Pipeline: the
// accepting edge loads the input stage, six more stages do the scale multiply
// and the divides by 1000, 100 and 10 through reciprocal multiplies, and the
// state and output register is loaded last.
// Configuration: cfg_we/cfg_index/cfg_data write dwell_ticks (index 0) or
// refresh_ticks (index 1); write only while no beats are in flight.
// Reset (rst, synchronous): registers return to 5000/500, temperatures and
// counters clear, the leftmost digit is selected, the pipeline empties.
// Stall: a stalled result holds; bubbles in the pipeline still close up, and
// item_stall rises once every stage is full behind the stalled result.
module temperature_seven_segment_display_top
  import tssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [9:0]  sample,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  segments,
  output logic [3:0]  digit_select,
  output logic [15:0] latest_temp
);

  localparam int unsigned NSTG = 7;

  pipe_t            stg [NSTG];
  logic [NSTG-1:0]  stg_valid;
  logic [NSTG:0]    load;
  pipe_t            in_beat;
  logic             fire;

  logic [15:0] dwell_ticks;
  logic [15:0] refresh_ticks;
  logic [15:0] latest_hundredths, latest_hundredths_next;
  digits_t     latest_digits, latest_digits_next;
  digits_t     shown_digits, shown_digits_next;
  logic        first_captured, first_captured_next;
  logic [15:0] refresh_counter, refresh_counter_next;
  logic [1:0]  digit_index, digit_index_next;
  logic [15:0] dwell_counter, dwell_counter_next;
  logic [7:0]  segments_next;

  pipe_t       fin;
  digits_t     fin_digits;
  logic [6:0]  ud_full;
  logic [16:0] dwell_inc;
  logic [16:0] refresh_inc;
  logic [5:0]  cur_digit;

  function automatic pipe_t stage_step(input int unsigned k, input pipe_t d);
    pipe_t       r;
    logic [21:0] p1;
    logic [32:0] p2;
    logic [15:0] t3;
    logic [15:0] p4;
    logic [9:0]  t5;
    logic [14:0] p6;
    r  = d;
    p1 = 22'(d.sample) * SCALE_MUL;
    p2 = 33'(d.hund) * DIV1000_MUL;
    t3 = d.hund - 16'(d.th) * 16'd1000;
    p4 = 16'(d.r1) * DIV100_MUL;
    t5 = d.r1 - 10'(d.hd) * 10'd100;
    p6 = 15'(d.r2) * DIV10_MUL;
    case (k)
      1: r.hund = p1[21:6];
      2: r.th   = p2[31:26];
      3: r.r1   = t3[9:0];
      4: r.hd   = p4[15:12];
      5: r.r2   = t5[6:0];
      6: r.td   = p6[14:11];
      default: ;
    endcase
    return r;
  endfunction

  always_comb begin
    in_beat        = '0;
    in_beat.cmd    = cmd;
    in_beat.sample = sample;
  end

  always_comb begin
    load[NSTG] = !result_valid || !result_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      load[i] = !stg_valid[i] || load[i+1];
    end
  end

  assign item_stall = !load[0];
  assign fire       = stg_valid[NSTG-1] && load[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      if (load[0]) begin
        stg_valid[0] <= item_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (load[i]) begin
          stg_valid[i] <= stg_valid[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      stg[0] <= in_beat;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (load[i]) begin
        stg[i] <= stage_step(i, stg[i-1]);
      end
    end
  end

  always_comb begin
    fin           = stg[NSTG-1];
    ud_full       = fin.r2 - 7'(fin.td) * 7'd10;
    fin_digits.th = fin.th;
    fin_digits.hd = fin.hd;
    fin_digits.td = fin.td;
    fin_digits.ud = ud_full[3:0];
    dwell_inc     = 17'(dwell_counter) + 17'd1;
    refresh_inc   = 17'(refresh_counter) + 17'd1;

    latest_hundredths_next = latest_hundredths;
    latest_digits_next     = latest_digits;
    shown_digits_next      = shown_digits;
    first_captured_next    = first_captured;
    refresh_counter_next   = refresh_counter;
    digit_index_next       = digit_index;
    dwell_counter_next     = dwell_counter;

    if (fire) begin
      case (fin.cmd)
        CMD_SAMPLE: begin
          latest_hundredths_next = fin.hund;
          latest_digits_next     = fin_digits;
          if (!first_captured) begin
            shown_digits_next   = fin_digits;
            first_captured_next = 1'b1;
          end
        end
        CMD_SCAN: begin
          if (dwell_inc >= 17'(dwell_ticks)) begin
            dwell_counter_next = '0;
            digit_index_next   = digit_index + 2'd1;
          end else begin
            dwell_counter_next = dwell_inc[15:0];
          end
        end
        CMD_REFRESH: begin
          if (refresh_inc >= 17'(refresh_ticks)) begin
            refresh_counter_next = '0;
            shown_digits_next    = latest_digits;
          end else begin
            refresh_counter_next = refresh_inc[15:0];
          end
        end
        default: ;
      endcase
    end

    case (digit_index_next)
      2'd0:    cur_digit = shown_digits_next.th;
      2'd1:    cur_digit = 6'(shown_digits_next.hd);
      2'd2:    cur_digit = 6'(shown_digits_next.td);
      default: cur_digit = 6'(shown_digits_next.ud);
    endcase
    segments_next = glyph(cur_digit);
    if (digit_index_next == 2'd1) begin
      segments_next = segments_next | SEG_DP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks       <= DWELL_RESET;
      refresh_ticks     <= REFRESH_RESET;
      latest_hundredths <= '0;
      latest_digits     <= '0;
      shown_digits      <= '0;
      first_captured    <= 1'b0;
      refresh_counter   <= '0;
      digit_index       <= '0;
      dwell_counter     <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DWELL:   dwell_ticks   <= cfg_data;
          REG_REFRESH: refresh_ticks <= cfg_data;
          default: ;
        endcase
      end
      latest_hundredths <= latest_hundredths_next;
      latest_digits     <= latest_digits_next;
      shown_digits      <= shown_digits_next;
      first_captured    <= first_captured_next;
      refresh_counter   <= refresh_counter_next;
      digit_index       <= digit_index_next;
      dwell_counter     <= dwell_counter_next;
      if (load[NSTG]) begin
        result_valid <= stg_valid[NSTG-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      segments     <= segments_next;
      digit_select <= 4'b0001 << digit_index_next;
      latest_temp  <= latest_hundredths_next;
    end
  end

endmodule

/* hw/rtl/tssd_checker.sv */
module tssd_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  segments,
  input logic [3:0]  digit_select,
  input logic [15:0] latest_temp
);

  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot(digit_select))
    else $error("digit enable not one-hot");

  a_dp_second: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (segments[0] == digit_select[1]))
    else $error("decimal point not on second digit");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (latest_temp <= 16'd49951))
    else $error("temperature out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(segments) && $stable(digit_select) && $stable(latest_temp))
    else $error("stalled beat changed");

endmodule

bind temperature_seven_segment_display_top tssd_checker u_tssd_checker (.*);
